// ===== sv/hea_pkg.sv =====
// Shared types and constants for the heater energy accumulator.
// No dependencies; imported by every module of the block.
package hea_pkg;

    localparam int TIME_W   = 32;
    localparam int POWER_W  = 8;
    localparam int TOTAL_W  = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;

    // Energy is tracked in units of 100 W*ms; one Wh is 36000 units.
    localparam int UNITS_PER_WH = 36000;
    localparam int UNIT_LSB_ZEROS = 5;          // 36000 = 1125 << 5
    localparam int ODD_DIVISOR = UNITS_PER_WH >> UNIT_LSB_ZEROS;

    localparam int UNITS_W  = 16;               // remainder, < 36000
    localparam int QUOT_W   = 17;               // elapsed / 36000
    localparam int PQ_W     = 25;               // power * quotient
    localparam int PR_W     = 24;               // power * remainder
    localparam int QA_W     = 8;                // (power * remainder) / 36000

    // Reciprocal of 1125 for 27-bit dividends.
    localparam int ELAPSED_X_W = TIME_W - UNIT_LSB_ZEROS;
    localparam int RECIP_E_W = 28;
    localparam int RECIP_E_SHIFT = 38;
    localparam logic [RECIP_E_W-1:0] RECIP_E = 28'd244335918;
    localparam int PROD_E_W = ELAPSED_X_W + RECIP_E_W;

    // Reciprocal of 1125 for 19-bit dividends.
    localparam int PR_X_W = PR_W - UNIT_LSB_ZEROS;
    localparam int RECIP_P_W = 20;
    localparam int RECIP_P_SHIFT = 30;
    localparam logic [RECIP_P_W-1:0] RECIP_P = 20'd954438;
    localparam int PROD_P_W = PR_X_W + RECIP_P_W;

    localparam logic [TIME_W-1:0] SAVE_INTERVAL_RESET = 32'd300000;

    localparam logic [CFG_IDX_W-1:0] CFG_POWER    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL = 2'd1;

    typedef struct packed {
        logic [TIME_W-1:0] now_ms;
        logic              heater_on;
        logic              clear_request;
        logic              clock_synced;
        logic [TIME_W-1:0] wall_time;
    } tick_t;

    typedef struct packed {
        tick_t             tick;
        logic [TIME_W-1:0] elapsed;
    } front_t;

    typedef struct packed {
        tick_t              tick;
        logic [UNITS_W-1:0] part_units;
        logic [PQ_W-1:0]    whole_wh;
    } work_t;

endpackage

// ===== sv/hea_ingress.sv =====
// Input register stage: captures a tick and the ms elapsed since the previous tick.
// Depends on hea_pkg.
module hea_ingress (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  hea_pkg::tick_t  tick,
    output logic            fwd_valid,
    input  logic            fwd_stall,
    output hea_pkg::front_t front
);
    import hea_pkg::*;

    logic              valid_reg;
    front_t            front_reg;
    logic [TIME_W-1:0] prev_ms_reg;
    logic              take;

    assign in_stall  = valid_reg && fwd_stall;
    assign take      = in_valid && !in_stall;
    assign fwd_valid = valid_reg;
    assign front     = front_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= 1'b0;
            prev_ms_reg <= '0;
        end
        else
        begin
            if (!in_stall)
            begin
                valid_reg <= in_valid;
            end
            if (take)
            begin
                prev_ms_reg <= tick.now_ms;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            front_reg.tick    <= tick;
            front_reg.elapsed <= tick.now_ms - prev_ms_reg;
        end
    end

endmodule

// ===== sv/hea_divider.sv =====
// Pipeline that splits power * elapsed into whole Wh and a sub-Wh part.
// Reciprocal multiplies stand in for the divides by 36000. Depends on hea_pkg.
module hea_divider (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [hea_pkg::POWER_W-1:0]   power,
    input  logic                          up_valid,
    output logic                          up_stall,
    input  hea_pkg::front_t               front,
    output logic                          dn_valid,
    input  logic                          dn_stall,
    output hea_pkg::work_t                work
);
    import hea_pkg::*;

    logic v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    logic st2, st3, st4, st5, st6;

    tick_t              tick2_reg, tick3_reg, tick4_reg, tick5_reg;
    logic [TIME_W-1:0]  elapsed2_reg;
    logic [QUOT_W-1:0]  q2_reg;
    logic [UNITS_W-1:0] r3_reg;
    logic [PQ_W-1:0]    pq3_reg, pq4_reg, pq5_reg;
    logic [PR_W-1:0]    pr4_reg, pr5_reg;
    logic [QA_W-1:0]    qa5_reg;
    work_t              work6_reg;

    logic [PROD_E_W-1:0] prod_e;
    logic [TIME_W:0]     q_times_div;
    logic [TIME_W:0]     r_full;
    logic [PROD_P_W-1:0] prod_p;
    logic [PR_W-1:0]     qa_times_div;
    logic [PR_W-1:0]     ra_full;

    assign st6 = v6_reg && dn_stall;
    assign st5 = v5_reg && st6;
    assign st4 = v4_reg && st5;
    assign st3 = v3_reg && st4;
    assign st2 = v2_reg && st3;
    assign up_stall = st2;
    assign dn_valid = v6_reg;
    assign work     = work6_reg;

    assign prod_e = PROD_E_W'(front.elapsed[TIME_W-1:UNIT_LSB_ZEROS]) * PROD_E_W'(RECIP_E);
    assign q_times_div = (TIME_W+1)'(q2_reg) * (TIME_W+1)'(UNITS_PER_WH);
    assign r_full = (TIME_W+1)'(elapsed2_reg) - q_times_div;
    assign prod_p = PROD_P_W'(pr4_reg[PR_W-1:UNIT_LSB_ZEROS]) * PROD_P_W'(RECIP_P);
    assign qa_times_div = PR_W'(qa5_reg) * PR_W'(UNITS_PER_WH);
    assign ra_full = pr5_reg - qa_times_div;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else
        begin
            if (!st2)
            begin
                v2_reg <= up_valid;
            end
            if (!st3)
            begin
                v3_reg <= v2_reg;
            end
            if (!st4)
            begin
                v4_reg <= v3_reg;
            end
            if (!st5)
            begin
                v5_reg <= v4_reg;
            end
            if (!st6)
            begin
                v6_reg <= v5_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!st2 && up_valid)
        begin
            tick2_reg    <= front.tick;
            elapsed2_reg <= front.elapsed;
            q2_reg       <= prod_e[RECIP_E_SHIFT +: QUOT_W];
        end
        if (!st3 && v2_reg)
        begin
            tick3_reg <= tick2_reg;
            r3_reg    <= r_full[UNITS_W-1:0];
            pq3_reg   <= PQ_W'(power) * PQ_W'(q2_reg);
        end
        if (!st4 && v3_reg)
        begin
            tick4_reg <= tick3_reg;
            pq4_reg   <= pq3_reg;
            pr4_reg   <= PR_W'(power) * PR_W'(r3_reg);
        end
        if (!st5 && v4_reg)
        begin
            tick5_reg <= tick4_reg;
            pq5_reg   <= pq4_reg;
            pr5_reg   <= pr4_reg;
            qa5_reg   <= prod_p[RECIP_P_SHIFT +: QA_W];
        end
        if (!st6 && v5_reg)
        begin
            work6_reg.tick       <= tick5_reg;
            work6_reg.part_units <= ra_full[UNITS_W-1:0];
            work6_reg.whole_wh   <= pq5_reg + PQ_W'(qa5_reg);
        end
    end

endmodule

// ===== sv/hea_integrator.sv =====
// Energy state, clear handling and store decision, followed by the result register.
// Depends on hea_pkg.
module hea_integrator (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [hea_pkg::TIME_W-1:0]   save_interval,
    input  logic                         up_valid,
    output logic                         up_stall,
    input  hea_pkg::work_t               work,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [hea_pkg::TOTAL_W-1:0]  total_wh,
    output logic [hea_pkg::TIME_W-1:0]   cleared_at,
    output logic                         store_total,
    output logic                         store_clear_time
);
    import hea_pkg::*;

    localparam logic [UNITS_W:0] UNITS_ONE_WH = (UNITS_W+1)'(UNITS_PER_WH);

    logic [UNITS_W-1:0] rem_reg, rem_next;
    logic [TOTAL_W-1:0] total_reg, total_next;
    logic [TOTAL_W-1:0] saved_reg, saved_next;
    logic [TIME_W-1:0]  last_store_reg, last_store_next;
    logic               was_on_reg;
    logic [TIME_W-1:0]  stamp_reg, stamp_next;
    logic               store_next;

    logic               out_valid_reg;
    logic [TOTAL_W-1:0] total_out_reg;
    logic [TIME_W-1:0]  stamp_out_reg;
    logic               store_out_reg;
    logic               clear_out_reg;

    logic [UNITS_W-1:0] rem_base;
    logic [TOTAL_W-1:0] total_base;
    logic [TOTAL_W-1:0] saved_base;
    logic [TIME_W-1:0]  last_base;
    logic [UNITS_W:0]   unit_sum;
    logic               carry;
    logic [TIME_W-1:0]  since_store;
    logic               turned_off;
    logic               store_due;
    logic               take;

    assign up_stall = out_valid_reg && out_stall;
    assign take     = up_valid && !up_stall;

    always_comb
    begin
        rem_base   = work.tick.clear_request ? '0 : rem_reg;
        total_base = work.tick.clear_request ? '0 : total_reg;
        saved_base = work.tick.clear_request ? '0 : saved_reg;
        last_base  = work.tick.clear_request ? work.tick.now_ms : last_store_reg;
        stamp_next = stamp_reg;
        if (work.tick.clear_request)
        begin
            stamp_next = work.tick.clock_synced ? work.tick.wall_time : '0;
        end

        unit_sum = (UNITS_W+1)'(work.part_units) + (UNITS_W+1)'(rem_base);
        carry    = unit_sum >= UNITS_ONE_WH;
        rem_next   = rem_base;
        total_next = total_base;
        if (work.tick.heater_on)
        begin
            rem_next   = carry ? UNITS_W'(unit_sum - UNITS_ONE_WH) : unit_sum[UNITS_W-1:0];
            total_next = total_base + TOTAL_W'(work.whole_wh) + TOTAL_W'(carry);
        end

        turned_off  = was_on_reg && !work.tick.heater_on;
        since_store = work.tick.now_ms - last_base;
        store_due   = (total_next != saved_base) && (turned_off || since_store >= save_interval);

        saved_next      = store_due ? total_next : saved_base;
        last_store_next = store_due ? work.tick.now_ms : last_base;
        store_next      = store_due || work.tick.clear_request;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg        <= '0;
            total_reg      <= '0;
            saved_reg      <= '0;
            last_store_reg <= '0;
            was_on_reg     <= 1'b0;
            stamp_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (!up_stall)
            begin
                out_valid_reg <= up_valid;
            end
            if (take)
            begin
                rem_reg        <= rem_next;
                total_reg      <= total_next;
                saved_reg      <= saved_next;
                last_store_reg <= last_store_next;
                was_on_reg     <= work.tick.heater_on;
                stamp_reg      <= stamp_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            total_out_reg <= total_next;
            stamp_out_reg <= stamp_next;
            store_out_reg <= store_next;
            clear_out_reg <= work.tick.clear_request;
        end
    end

    assign out_valid        = out_valid_reg;
    assign total_wh         = total_out_reg;
    assign cleared_at       = stamp_out_reg;
    assign store_total      = store_out_reg;
    assign store_clear_time = clear_out_reg;

endmodule

// ===== sv/heater_energy_accumulator.sv =====
// Top level of the heater energy accumulator: configuration registers and stage wiring.
// Depends on hea_pkg, hea_ingress, hea_divider, hea_integrator.
//
//   channel | signals                                          | direction
//   --------+--------------------------------------------------+----------
//   in      | in_valid, in_stall, now_ms .. wall_time          | tick in
//   out     | out_valid, out_stall, total_wh .. store_clear_time | result out
//   cfg     | cfg_we, cfg_index, cfg_data                      | write only
//
// One transaction per cycle sustained while out_stall is low; each tick passes the input
// register, five divide/multiply stages and the result register, in that order.
// Reset clears all pipeline valids and the energy state; save interval resets to 300000.
// out_stall holds the result register and backs up stage by stage; empty stages
// keep taking ticks.
module heater_energy_accumulator (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [hea_pkg::TIME_W-1:0]     now_ms,
    input  logic                           heater_on,
    input  logic                           clear_request,
    input  logic                           clock_synced,
    input  logic [hea_pkg::TIME_W-1:0]     wall_time,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [hea_pkg::TOTAL_W-1:0]    total_wh,
    output logic [hea_pkg::TIME_W-1:0]     cleared_at,
    output logic                           store_total,
    output logic                           store_clear_time,
    input  logic                           cfg_we,
    input  logic [hea_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [hea_pkg::CFG_DATA_W-1:0] cfg_data
);
    import hea_pkg::*;

    logic [POWER_W-1:0] power_reg;
    logic [TIME_W-1:0]  interval_reg;

    tick_t  tick_in;
    front_t front;
    work_t  work;
    logic   front_valid, front_stall;
    logic   work_valid, work_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            power_reg    <= '0;
            interval_reg <= SAVE_INTERVAL_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_POWER:    power_reg    <= cfg_data[POWER_W-1:0];
                CFG_INTERVAL: interval_reg <= cfg_data[TIME_W-1:0];
                default:      ;
            endcase
        end
    end

    assign tick_in.now_ms        = now_ms;
    assign tick_in.heater_on     = heater_on;
    assign tick_in.clear_request = clear_request;
    assign tick_in.clock_synced  = clock_synced;
    assign tick_in.wall_time     = wall_time;

    hea_ingress u_ingress (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .tick      (tick_in),
        .fwd_valid (front_valid),
        .fwd_stall (front_stall),
        .front     (front)
    );

    hea_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .power    (power_reg),
        .up_valid (front_valid),
        .up_stall (front_stall),
        .front    (front),
        .dn_valid (work_valid),
        .dn_stall (work_stall),
        .work     (work)
    );

    hea_integrator u_integrator (
        .clk              (clk),
        .rst_n            (rst_n),
        .save_interval    (interval_reg),
        .up_valid         (work_valid),
        .up_stall         (work_stall),
        .work             (work),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .total_wh         (total_wh),
        .cleared_at       (cleared_at),
        .store_total      (store_total),
        .store_clear_time (store_clear_time)
    );

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench for heater_energy_accumulator: ticks go in, watt-hour results are checked in order.
// A scoreboard class predicts each result. Depends on hea_pkg and the block's RTL.
module tb_top;
    import hea_pkg::*;

    localparam logic [63:0] WMS_PER_WH = 64'd3600000;
    localparam logic [63:0] WATTS_PER_DECI_KW = 64'd100;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;
    localparam int HOLD_CYCLES = 80;
    localparam int DRAIN_CYCLES = 12;

    typedef struct packed {
        logic [TOTAL_W-1:0] total_wh;
        logic [TIME_W-1:0]  cleared_at;
        logic               store_total;
        logic               store_clear_time;
    } meter_result_t;

    class energy_scoreboard;
        logic [POWER_W-1:0] power_dkw;
        logic [TIME_W-1:0]  interval_ms;
        logic [21:0]        rem_wms;
        logic [TOTAL_W-1:0] energy_wh;
        logic [TOTAL_W-1:0] stored_wh;
        logic [TIME_W-1:0]  prev_ms;
        logic [TIME_W-1:0]  last_store_ms;
        logic               was_on;
        logic [TIME_W-1:0]  clear_stamp;
        meter_result_t      due_q[$];
        int                 failures;

        function new();
            power_dkw = '0;
            interval_ms = SAVE_INTERVAL_RESET;
            rem_wms = '0;
            energy_wh = '0;
            stored_wh = '0;
            prev_ms = '0;
            last_store_ms = '0;
            was_on = 1'b0;
            clear_stamp = '0;
            failures = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_POWER:    power_dkw = data[POWER_W-1:0];
                CFG_INTERVAL: interval_ms = data[TIME_W-1:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return due_q.size();
        endfunction

        function void note_tick(tick_t t);
            logic [TIME_W-1:0] elapsed;
            logic [TIME_W-1:0] since_store;
            logic [63:0]       watts;
            logic [63:0]       sum;
            logic [63:0]       whole;
            logic [63:0]       frac;
            logic              store;
            logic              turned_off;
            meter_result_t     r;
            elapsed = t.now_ms - prev_ms;
            prev_ms = t.now_ms;
            store = 1'b0;
            if (t.clear_request) begin
                rem_wms = '0;
                energy_wh = '0;
                clear_stamp = t.clock_synced ? t.wall_time : '0;
                stored_wh = '0;
                last_store_ms = t.now_ms;
                store = 1'b1;
            end
            if (t.heater_on) begin
                watts = {56'd0, power_dkw} * WATTS_PER_DECI_KW;
                sum = watts * {32'd0, elapsed} + {42'd0, rem_wms};
                whole = sum / WMS_PER_WH;
                frac = sum % WMS_PER_WH;
                rem_wms = frac[21:0];
                energy_wh = energy_wh + whole[31:0];
            end
            turned_off = was_on && !t.heater_on;
            was_on = t.heater_on;
            since_store = t.now_ms - last_store_ms;
            if (energy_wh != stored_wh && (turned_off || since_store >= interval_ms)) begin
                stored_wh = energy_wh;
                last_store_ms = t.now_ms;
                store = 1'b1;
            end
            r.total_wh = energy_wh;
            r.cleared_at = clear_stamp;
            r.store_total = store;
            r.store_clear_time = t.clear_request;
            due_q.push_back(r);
        endfunction

        function void mismatch(string field, logic [31:0] want_v, logic [31:0] got_v);
            failures++;
            if (failures <= 40)
                $display("%0t: %s expected %0d actual %0d", $time, field, want_v, got_v);
        endfunction

        function void check_result(meter_result_t got);
            meter_result_t want;
            if (due_q.size() == 0) begin
                failures++;
                if (failures <= 40)
                    $display("%0t: result with no transaction pending, total_wh %0d",
                             $time, got.total_wh);
                return;
            end
            want = due_q.pop_front();
            if (got.total_wh !== want.total_wh)
                mismatch("total_wh", want.total_wh, got.total_wh);
            if (got.cleared_at !== want.cleared_at)
                mismatch("cleared_at", want.cleared_at, got.cleared_at);
            if (got.store_total !== want.store_total)
                mismatch("store_total", 32'(want.store_total), 32'(got.store_total));
            if (got.store_clear_time !== want.store_clear_time)
                mismatch("store_clear_time", 32'(want.store_clear_time),
                         32'(got.store_clear_time));
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic [TIME_W-1:0]     now_ms;
    logic                  heater_on;
    logic                  clear_request;
    logic                  clock_synced;
    logic [TIME_W-1:0]     wall_time;
    logic                  out_valid;
    logic                  out_stall;
    logic [TOTAL_W-1:0]    total_wh;
    logic [TIME_W-1:0]     cleared_at;
    logic                  store_total;
    logic                  store_clear_time;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    energy_scoreboard  sb;
    bit                hold_off_req;
    int                no_gap_left;
    int                burst_left;
    logic [TIME_W-1:0] ms_cursor;
    logic              relay_state;

    heater_energy_accumulator dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .now_ms(now_ms),
        .heater_on(heater_on),
        .clear_request(clear_request),
        .clock_synced(clock_synced),
        .wall_time(wall_time),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .total_wh(total_wh),
        .cleared_at(cleared_at),
        .store_total(store_total),
        .store_clear_time(store_clear_time),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #1 clk = ~clk;

    task automatic send_tick(input tick_t t);
        in_valid <= 1'b1;
        now_ms <= t.now_ms;
        heater_on <= t.heater_on;
        clear_request <= t.clear_request;
        clock_synced <= t.clock_synced;
        wall_time <= t.wall_time;
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
        sb.note_tick(t);
    endtask

    task automatic pace();
        int gap;
        if (no_gap_left > 0) begin
            no_gap_left--;
            return;
        end
        if (burst_left > 0) begin
            burst_left--;
            return;
        end
        gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 8);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        burst_left = $urandom_range(1, 24);
    endtask

    task automatic wait_drained();
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        sb.write_reg(idx, data);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // block must be empty before any register write
    task automatic setup_phase(input logic [POWER_W-1:0] power, input logic [TIME_W-1:0] interval);
        logic [CFG_DATA_W-1:0] d;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        d = $urandom;
        d[POWER_W-1:0] = power;
        cfg_write(CFG_POWER, d);
        cfg_write(CFG_INTERVAL, interval);
        cfg_write(CFG_SPARE_LO, $urandom);
        cfg_write(CFG_SPARE_HI, $urandom);
    endtask

    function automatic tick_t tick_of(logic [TIME_W-1:0] now, logic on, logic clr, logic sync,
                                      logic [TIME_W-1:0] wall);
        tick_t t;
        t.now_ms = now;
        t.heater_on = on;
        t.clear_request = clr;
        t.clock_synced = sync;
        t.wall_time = wall;
        return t;
    endfunction

    function automatic tick_t make_tick(int clear_pct, bit heavy);
        tick_t             t;
        int                pick;
        logic [TIME_W-1:0] delta;
        pick = $urandom_range(0, 99);
        if (heavy)
            delta = 32'hFFFF_FFFF - $urandom_range(0, 1000);
        else if (pick < 50)
            delta = $urandom_range(0, 2000);
        else if (pick < 75)
            delta = $urandom_range(0, 600000);
        else if (pick < 90)
            delta = $urandom;
        else
            delta = '0;
        ms_cursor = ms_cursor + delta;
        if (heavy)
            relay_state = ($urandom_range(0, 39) != 0);
        else if ($urandom_range(0, 3) == 0)
            relay_state = ~relay_state;
        t.now_ms = ms_cursor;
        t.heater_on = relay_state;
        t.clear_request = ($urandom_range(0, 99) < clear_pct);
        t.clock_synced = ($urandom_range(0, 9) < 7);
        t.wall_time = $urandom;
        return t;
    endfunction

    task automatic run_directed();
        setup_phase(8'd255, 32'd0);
        send_tick(tick_of(32'd1000, 1'b1, 1'b0, 1'b1, 32'd0));
        send_tick(tick_of(32'd1000, 1'b1, 1'b0, 1'b0, 32'd0));
        send_tick(tick_of(32'hFFFF_FFFF, 1'b1, 1'b0, 1'b1, 32'hFFFF_FFFF));
        send_tick(tick_of(32'd5, 1'b1, 1'b0, 1'b0, 32'd0));
        send_tick(tick_of(32'd5000, 1'b0, 1'b0, 1'b1, 32'd1));
        send_tick(tick_of(32'd10000, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF));
        send_tick(tick_of(32'd20000, 1'b1, 1'b1, 1'b0, 32'h1234_5678));
        send_tick(tick_of(32'd20000, 1'b0, 1'b1, 1'b1, 32'd0));
        send_tick(tick_of(32'h8000_0000, 1'b1, 1'b0, 1'b1, $urandom));
        send_tick(tick_of(32'h8000_0000, 1'b1, 1'b1, 1'b1, $urandom));
        send_tick(tick_of(32'h7FFF_FFFF, 1'b1, 1'b0, 1'b0, 32'hAAAA_5555));
        send_tick(tick_of(32'h7FFF_FFFF, 1'b0, 1'b0, 1'b1, 32'h5555_AAAA));
        send_tick(tick_of(32'h8000_0E0F, 1'b1, 1'b0, 1'b1, $urandom));
        in_valid <= 1'b0;
        // no periodic store: only turn-off and clear save
        setup_phase(8'd255, 32'hFFFF_FFFF);
        send_tick(tick_of(32'h8000_1000, 1'b1, 1'b0, 1'b1, $urandom));
        send_tick(tick_of(32'h8000_2000, 1'b1, 1'b0, 1'b1, $urandom));
        send_tick(tick_of(32'h8000_3000, 1'b0, 1'b0, 1'b1, $urandom));
        send_tick(tick_of(32'h8000_4000, 1'b0, 1'b0, 1'b0, $urandom));
        send_tick(tick_of(32'h8000_5000, 1'b1, 1'b1, 1'b1, $urandom));
        in_valid <= 1'b0;
        ms_cursor = 32'h8000_5000;
        relay_state = 1'b1;
    endtask

    task automatic run_phase(input logic [POWER_W-1:0] power, input logic [TIME_W-1:0] interval,
                             input int count, input int clear_pct, input bit heavy,
                             input int hold_at, input int pause_at);
        setup_phase(power, interval);
        for (int i = 0; i < count; i++) begin
            if (i == hold_at) begin
                hold_off_req = 1'b1;
                no_gap_left = 40;
            end
            if (i == pause_at) begin
                in_valid <= 1'b0;
                wait_drained();
                @(posedge clk);
            end
            pace();
            send_tick(make_tick(clear_pct, heavy));
        end
        in_valid <= 1'b0;
    endtask

    initial begin : result_sink
        int            mode;
        int            mode_left;
        int            hold_left;
        meter_result_t got;
        mode = 0;
        mode_left = 0;
        hold_left = 0;
        forever begin
            @(posedge clk);
            if (out_valid === 1'b1 && out_stall == 1'b0) begin
                got.total_wh = total_wh;
                got.cleared_at = cleared_at;
                got.store_total = store_total;
                got.store_clear_time = store_clear_time;
                sb.check_result(got);
            end
            if (hold_off_req) begin
                hold_left = HOLD_CYCLES;
                hold_off_req = 1'b0;
            end
            if (mode_left == 0) begin
                mode = $urandom_range(0, 3);
                mode_left = $urandom_range(16, 64);
            end
            mode_left--;
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else begin
                case (mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 3) == 0);
                    2: out_stall <= ($urandom_range(0, 3) != 0);
                    default: out_stall <= ~out_stall;
                endcase
            end
        end
    end

    initial begin
        #400000;
        $display("FAILED: results differ");
        $finish;
    end

    initial begin
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        now_ms = '0;
        heater_on = 1'b0;
        clear_request = 1'b0;
        clock_synced = 1'b0;
        wall_time = '0;
        out_stall = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        hold_off_req = 1'b0;
        no_gap_left = 0;
        burst_left = 0;
        ms_cursor = '0;
        relay_state = 1'b0;
        sb = new();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        run_phase(8'd0, 32'hFFFF_FFFF, 70, 5, 1'b0, -1, -1);
        // long runs at full power so the total wraps
        run_phase(8'd255, 32'd300000, 150, 0, 1'b1, -1, -1);
        run_phase(POWER_W'($urandom_range(1, 254)), $urandom_range(0, 1000000), 100, 5, 1'b0,
                  30, -1);
        run_phase(8'd1, 32'd0, 80, 8, 1'b0, -1, 40);
        run_phase(POWER_W'($urandom_range(1, 254)), $urandom, 80, 5, 1'b0, 50, -1);
        run_phase(8'd255, 32'd1000, 80, 5, 1'b0, -1, 30);
        wait_drained();
        repeat (20) @(posedge clk);
        if (sb.failures == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule
